[sv/sobel4_pkg.sv]
// Shared types, constants and helpers for the four-direction Sobel edge map.
// No dependencies; imported by every module of the block.
`default_nettype none

package sobel4_pkg;

  // Line store geometry and frame size limits
  localparam int MaxWidth  = 256;
  localparam int MaxHeight = 256;
  localparam int IdxW      = $clog2(MaxWidth);
  localparam int SizeW     = 9;

  // Window queue between front and back
  localparam int QDepth = 4;
  localparam int QAw    = $clog2(QDepth);
  localparam int QCw    = QAw + 1;

  // Configuration register indexes
  localparam int CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_EDGE_MODE      = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_EDGE_THRESHOLD = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_FRAME_WIDTH    = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_FRAME_HEIGHT   = 2'd3;

  // Reset values of the registers
  localparam logic [7:0]       RST_EDGE_THRESHOLD = 8'd80;
  localparam logic [SizeW-1:0] RST_FRAME_WIDTH    = 9'd188;
  localparam logic [SizeW-1:0] RST_FRAME_HEIGHT   = 9'd120;

  // Input pixel transaction
  typedef struct packed {
    logic [7:0] pixel;
    logic       frame_start;
  } pix_in_t;

  // Result transaction
  typedef struct packed {
    logic       edge_res;
    logic [7:0] row;
    logic [7:0] column;
    logic       frame_done;
  } res_out_t;

  // Register file contents
  typedef struct packed {
    logic             edge_mode;
    logic [7:0]       edge_threshold;
    logic [SizeW-1:0] frame_width;
    logic [SizeW-1:0] frame_height;
  } cfg_t;

  // Complete 3x3 window of an interior pixel; win[i] is pixel i in raster order
  typedef struct packed {
    logic [8:0][7:0] win;
    logic [7:0]      row;
    logic [7:0]      column;
    logic            frame_done;
  } win_item_t;

  // Queue status seen by the front
  typedef struct packed {
    logic [QCw-1:0] count;
    logic           nonempty;
  } q_stat_t;

  // Sum of three pixels
  function automatic logic [9:0] sum3(input logic [7:0] x, input logic [7:0] y,
                                      input logic [7:0] z);
    sum3 = 10'(x) + 10'(y) + 10'(z);
  endfunction

  // Absolute difference of two three-pixel sums
  function automatic logic [9:0] abs_diff(input logic [9:0] p, input logic [9:0] q);
    abs_diff = (p > q) ? (p - q) : (q - p);
  endfunction

endpackage

`default_nettype wire

[sv/sobel4_queue.sv]
// Short window queue that decouples the front (line stores) from the back (gradients).
// Depends on sobel4_pkg.
`default_nettype none

module sobel4_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  sobel4_pkg::win_item_t push_item,
  input  logic                  pop,
  output sobel4_pkg::win_item_t head,
  output sobel4_pkg::q_stat_t   stat
);
  import sobel4_pkg::*;

  win_item_t        entries [QDepth];
  logic [QAw-1:0]   wr_ptr;
  logic [QAw-1:0]   rd_ptr;
  logic [QCw-1:0]   count;

  function automatic logic [QAw-1:0] ptr_inc(input logic [QAw-1:0] p);
    ptr_inc = (p == QAw'(QDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign head          = entries[rd_ptr];
  assign stat.count    = count;
  assign stat.nonempty = (count != '0);

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ptr_inc(wr_ptr);
      if (pop)  rd_ptr <= ptr_inc(rd_ptr);
      if (push && !pop)      count <= count + 1'b1;
      else if (!push && pop) count <= count - 1'b1;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_item;
  end

endmodule

`default_nettype wire

[sv/sobel4_front.sv]
// Front of the edge map: position counters, two line stores and the 3x3 window.
// Pushes one window per interior pixel into the queue. Depends on sobel4_pkg.
`default_nettype none

module sobel4_front (
  input  logic                  clk,
  input  logic                  rst,
  input  sobel4_pkg::cfg_t      cfg,
  input  logic                  pix_valid,
  output logic                  pix_stall,
  input  sobel4_pkg::pix_in_t   pix,
  input  sobel4_pkg::q_stat_t   q_stat,
  output logic                  push,
  output sobel4_pkg::win_item_t push_item
);
  import sobel4_pkg::*;

  // Line stores
  logic [7:0] upper  [MaxWidth];
  logic [7:0] middle [MaxWidth];
  logic [7:0] up_rd;
  logic [7:0] mid_rd;

  // Position counters
  logic [IdxW-1:0] column_count;
  logic [IdxW-1:0] row_count;

  // Second stage: pixel whose store read is back
  logic            s1_valid;
  logic [7:0]      s1_px;
  logic [IdxW-1:0] s1_idx;
  logic            s1_int;
  logic [7:0]      s1_row;
  logic [7:0]      s1_col;
  logic            s1_done;
  logic            s1_byp;
  logic [7:0]      byp_up;
  logic [7:0]      byp_mid;

  logic [8:0][7:0] win;
  logic [8:0][7:0] win_next;

  logic [SizeW-1:0] w_eff;
  logic [SizeW-1:0] h_eff;
  logic [IdxW-1:0]  col_cur;
  logic [IdxW-1:0]  row_cur;
  logic [SizeW-1:0] col_inc;
  logic [SizeW-1:0] row_inc;
  logic             accept;
  logic [7:0]       up_eff;
  logic [7:0]       mid_eff;

  // Frame size clamped to [3, max]
  always_comb begin
    if (cfg.frame_width < SizeW'(3))             w_eff = SizeW'(3);
    else if (cfg.frame_width > SizeW'(MaxWidth)) w_eff = SizeW'(MaxWidth);
    else                                         w_eff = cfg.frame_width;
    if (cfg.frame_height < SizeW'(3))              h_eff = SizeW'(3);
    else if (cfg.frame_height > SizeW'(MaxHeight)) h_eff = SizeW'(MaxHeight);
    else                                           h_eff = cfg.frame_height;
  end

  // Position of the incoming pixel
  assign col_cur = pix.frame_start ? '0 : column_count;
  assign row_cur = pix.frame_start ? '0 : row_count;
  assign col_inc = SizeW'(col_cur) + 1'b1;
  assign row_inc = SizeW'(row_cur) + 1'b1;

  // Hold off input while the queue could not take every window in flight
  assign pix_stall = (QCw'(q_stat.count) + QCw'(s1_valid && s1_int)) >= QCw'(QDepth);
  assign accept    = pix_valid && !pix_stall;

  // Store data, with forwarding when the previous pixel wrote the same entry
  assign up_eff  = s1_byp ? byp_up  : up_rd;
  assign mid_eff = s1_byp ? byp_mid : mid_rd;

  // Window slides left, new column enters on the right
  always_comb begin
    win_next    = win;
    win_next[0] = win[1];
    win_next[1] = win[2];
    win_next[2] = up_eff;
    win_next[3] = win[4];
    win_next[4] = win[5];
    win_next[5] = mid_eff;
    win_next[6] = win[7];
    win_next[7] = win[8];
    win_next[8] = s1_px;
  end

  assign push                 = s1_valid && s1_int;
  assign push_item.win        = win_next;
  assign push_item.row        = s1_row;
  assign push_item.column     = s1_col;
  assign push_item.frame_done = s1_done;

  // Line stores: read on accept, read-modify-write in the next cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      up_rd  <= upper[col_cur];
      mid_rd <= middle[col_cur];
    end
    if (s1_valid) begin
      upper[s1_idx]  <= mid_eff;
      middle[s1_idx] <= s1_px;
      win            <= win_next;
    end
  end

  // Control: counters and stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      s1_valid     <= 1'b0;
    end else begin
      s1_valid <= accept;
      if (accept) begin
        if (col_inc >= w_eff) begin
          column_count <= '0;
          row_count    <= (row_inc >= h_eff) ? '0 : row_inc[IdxW-1:0];
        end else begin
          column_count <= col_inc[IdxW-1:0];
          row_count    <= row_cur;
        end
      end
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_px   <= pix.pixel;
      s1_idx  <= col_cur;
      s1_int  <= (row_cur >= IdxW'(2)) && (col_cur >= IdxW'(2));
      s1_row  <= 8'(row_cur - 1'b1);
      s1_col  <= 8'(col_cur - 1'b1);
      s1_done <= (SizeW'(row_cur) == h_eff - 1'b1) && (SizeW'(col_cur) == w_eff - 1'b1);
      s1_byp  <= s1_valid && (s1_idx == col_cur);
      byp_up  <= mid_eff;
      byp_mid <= s1_px;
    end
  end

endmodule

`default_nettype wire

[sv/sobel4_back.sv]
// Back of the edge map: four gradients, largest magnitude, threshold decision.
// Three stages ending in the output register. Depends on sobel4_pkg.
`default_nettype none

module sobel4_back (
  input  logic                  clk,
  input  logic                  rst,
  input  sobel4_pkg::cfg_t      cfg,
  input  sobel4_pkg::q_stat_t   q_stat,
  input  sobel4_pkg::win_item_t head,
  output logic                  pop,
  output logic                  res_valid,
  input  logic                  res_stall,
  output sobel4_pkg::res_out_t  res
);
  import sobel4_pkg::*;

  logic adv;

  // Stage 1: gradient magnitudes and window sum
  logic            b1_valid;
  logic [3:0][9:0] b1_grad;
  logic [11:0]     b1_sum;
  logic [7:0]      b1_row;
  logic [7:0]      b1_col;
  logic            b1_done;

  // Stage 2: largest magnitude
  logic            b2_valid;
  logic [9:0]      b2_max;
  logic [11:0]     b2_sum;
  logic [7:0]      b2_row;
  logic [7:0]      b2_col;
  logic            b2_done;

  logic [3:0][9:0] grad;
  logic [11:0]     sum9;
  logic [9:0]      max01;
  logic [9:0]      max23;
  logic [9:0]      max_all;
  logic [13:0]     max12;
  logic            edge_dec;

  assign adv = !res_valid || !res_stall;
  assign pop = adv && q_stat.nonempty;

  // Gradients over the window a..i = win[0..8]
  always_comb begin
    grad[0] = abs_diff(sum3(head.win[2], head.win[5], head.win[8]),
                       sum3(head.win[0], head.win[3], head.win[6]));
    grad[1] = abs_diff(sum3(head.win[6], head.win[7], head.win[8]),
                       sum3(head.win[0], head.win[1], head.win[2]));
    grad[2] = abs_diff(sum3(head.win[3], head.win[7], head.win[6]),
                       sum3(head.win[1], head.win[5], head.win[2]));
    grad[3] = abs_diff(sum3(head.win[5], head.win[7], head.win[8]),
                       sum3(head.win[1], head.win[3], head.win[0]));
    sum9 = 12'(sum3(head.win[0], head.win[1], head.win[2]))
         + 12'(sum3(head.win[3], head.win[4], head.win[5]))
         + 12'(sum3(head.win[6], head.win[7], head.win[8]));
  end

  // Max tree
  always_comb begin
    max01   = (b1_grad[1] > b1_grad[0]) ? b1_grad[1] : b1_grad[0];
    max23   = (b1_grad[3] > b1_grad[2]) ? b1_grad[3] : b1_grad[2];
    max_all = (max23 > max01) ? max23 : max01;
  end

  // Decision: 12*g = 8g + 4g
  assign max12    = 14'({b2_max, 3'b000}) + 14'({b2_max, 2'b00});
  assign edge_dec = cfg.edge_mode ? (max12 > 14'(b2_sum))
                                  : (b2_max > 10'(cfg.edge_threshold));

  // Stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid  <= 1'b0;
      b2_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else if (adv) begin
      b1_valid  <= q_stat.nonempty;
      b2_valid  <= b1_valid;
      res_valid <= b2_valid;
    end
  end

  // Stage payloads
  always_ff @(posedge clk) begin
    if (adv) begin
      b1_grad        <= grad;
      b1_sum         <= sum9;
      b1_row         <= head.row;
      b1_col         <= head.column;
      b1_done        <= head.frame_done;
      b2_max         <= max_all;
      b2_sum         <= b1_sum;
      b2_row         <= b1_row;
      b2_col         <= b1_col;
      b2_done        <= b1_done;
      res.edge_res   <= edge_dec;
      res.row        <= b2_row;
      res.column     <= b2_col;
      res.frame_done <= b2_done;
    end
  end

endmodule

`default_nettype wire

[sv/four_direction_sobel_edge_map_core.sv]
// Top level of the four-direction Sobel edge map: registers, front, queue, back.
// Depends on sobel4_pkg, sobel4_front, sobel4_queue, sobel4_back.
//
//   Channel   Signals                       Direction  Transaction
//   pixel     pix_valid / pix_stall / pix   in         one grey pixel, raster order
//   result    res_valid / res_stall / res   out        one judged interior pixel
//   config    cfg_we / cfg_index / cfg_data in         one register write
//
// One pixel per cycle while pix_stall is low; the line stores take one read-modify-write per pixel.
// An accepted interior pixel passes the front's second stage, a queue entry, b1, b2 and res.
// A 4-entry queue lets the result side stall without stopping the line stores at once;
// pix_stall rises only when the queue could not hold the windows in flight.
// Synchronous reset clears counters, valids and registers; line stores are not cleared.
`default_nettype none

module four_direction_sobel_edge_map_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 pix_valid,
  output logic                                 pix_stall,
  input  sobel4_pkg::pix_in_t                  pix,
  output logic                                 res_valid,
  input  logic                                 res_stall,
  output sobel4_pkg::res_out_t                 res,
  input  logic                                 cfg_we,
  input  logic [sobel4_pkg::CfgIdxW-1:0]       cfg_index,
  input  logic [sobel4_pkg::SizeW-1:0]         cfg_data
);
  import sobel4_pkg::*;

  cfg_t      cfg;
  q_stat_t   q_stat;
  logic      push;
  win_item_t push_item;
  logic      pop;
  win_item_t head;

  // Register file
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.edge_mode      <= 1'b0;
      cfg.edge_threshold <= RST_EDGE_THRESHOLD;
      cfg.frame_width    <= RST_FRAME_WIDTH;
      cfg.frame_height   <= RST_FRAME_HEIGHT;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_EDGE_MODE:      cfg.edge_mode      <= cfg_data[0];
        CFG_EDGE_THRESHOLD: cfg.edge_threshold <= cfg_data[7:0];
        CFG_FRAME_WIDTH:    cfg.frame_width    <= cfg_data;
        CFG_FRAME_HEIGHT:   cfg.frame_height   <= cfg_data;
        default: ;
      endcase
    end
  end

  sobel4_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .pix       (pix),
    .q_stat    (q_stat),
    .push      (push),
    .push_item (push_item)
  );

  sobel4_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .stat      (q_stat)
  );

  sobel4_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_stat    (q_stat),
    .head      (head),
    .pop       (pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule

`default_nettype wire

[sv/sobel4_checker.sv]
// Port-level checks for the edge map core, attached by bind.
// Depends on sobel4_pkg and four_direction_sobel_edge_map_core.
`default_nettype none

module sobel4_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 pix_stall,
  input logic                 res_valid,
  input logic                 res_stall,
  input sobel4_pkg::res_out_t res
);
  import sobel4_pkg::*;

  // A stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res))
    else $error("stalled result changed");

  // Reset empties the result side
  a_rst_res: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  // Reset empties the queue, so input is open
  a_rst_pix: assert property (@(posedge clk) rst |=> !pix_stall)
    else $error("input stalled after reset");

  // Results are interior pixels only; checked against the top row and left column
  a_interior: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res.row != 8'd0) && (res.column != 8'd0))
    else $error("result on the frame border");

endmodule

bind four_direction_sobel_edge_map_core sobel4_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .pix_stall (pix_stall),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res       (res)
);

`default_nettype wire
